/* sv/cbcs_pkg.sv */
// ----------------------------------------------------------------------------
// cbcs_pkg
// Shared widths and register codes for the brightness, contrast and
// saturation colour filter.
// ----------------------------------------------------------------------------
package cbcs_pkg;

	// width of the signed value fed to a renormaliser, enough for any
	// intermediate result up to sixteen fraction bits
	localparam int RENORM_W = 19;

	// configuration register width and index width
	localparam int GAIN_W    = 16;
	localparam int CFG_IDX_W = 2;

	// output component width
	localparam int OUT_W = 13;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BRIGHTNESS = 2'd0,
		CFG_SATURATION = 2'd1,
		CFG_CONTRAST   = 2'd2
	} cfg_reg_t;

endpackage

/* sv/cbcs_renorm.sv */
// ----------------------------------------------------------------------------
// cbcs_renorm
// Pipelined pixel renormaliser: clamps negative components to zero and, when
// the largest component exceeds one, divides all three by it, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module cbcs_renorm
	import cbcs_pkg::*;
#(
	parameter int FRACTION_BITS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [RENORM_W-1:0] in_c [3],
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [FRACTION_BITS:0]     out_c [3]
);

	localparam int CW = FRACTION_BITS + 1;
	localparam int NS = FRACTION_BITS + 2;
	localparam int MW = RENORM_W - 1;
	localparam logic [MW-1:0] ONE_M = MW'(1) << FRACTION_BITS;

	logic [MW-1:0] cl [3];
	logic [MW-1:0] mx;
	logic          big;

	logic          v_s   [NS];
	logic          rdy   [NS+1];
	logic [MW-1:0] rem_s [NS][3];
	logic [CW-1:0] quo_s [NS][3];
	logic [MW-1:0] div_s [NS];
	logic          big_s [NS];

	// clamp negatives and find the largest component
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cl[i] = in_c[i][RENORM_W-1] ? '0 : in_c[i][MW-1:0];
		end
		mx = cl[0];
		if (cl[1] > mx) mx = cl[1];
		if (cl[2] > mx) mx = cl[2];
		big = (mx > ONE_M);
	end

	// stall chain, a stage loads when it is empty or its successor moves
	assign rdy[NS] = out_ready;
	for (genvar k = 0; k < NS; k++) begin : g_rdy
		assign rdy[k] = !v_s[k] || rdy[k+1];
	end
	assign in_ready = rdy[0];

	// clamp stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			div_s[0] <= mx;
			big_s[0] <= big;
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i] <= cl[i];
				// below one the clamped value already is the result
				quo_s[0][i] <= big ? '0 : cl[i][CW-1:0];
			end
		end
	end

	// restoring division, quotient bit FRACTION_BITS-k+1 at stage k
	for (genvar k = 1; k < NS; k++) begin : g_step
		logic [MW:0] trial [3];
		logic [MW:0] diff  [3];
		logic        ge    [3];

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				if (k == 1) begin
					trial[i] = {1'b0, rem_s[k-1][i]};
				end else begin
					trial[i] = {rem_s[k-1][i], 1'b0};
				end
				diff[i] = trial[i] - {1'b0, div_s[k-1]};
				ge[i]   = (trial[i] >= {1'b0, div_s[k-1]});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				div_s[k] <= div_s[k-1];
				big_s[k] <= big_s[k-1];
				for (int i = 0; i < 3; i++) begin
					rem_s[k][i] <= ge[i] ? diff[i][MW-1:0] : trial[i][MW-1:0];
					quo_s[k][i] <= big_s[k-1] ? {quo_s[k-1][i][CW-2:0], ge[i]}
						: quo_s[k-1][i];
				end
			end
		end
	end

	assign out_valid = v_s[NS-1];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			out_c[i] = quo_s[NS-1][i];
		end
	end

endmodule

/* sv/color_brightness_contrast_saturation.sv */
// ----------------------------------------------------------------------------
// color_brightness_contrast_saturation
// Brightness, contrast and saturation adjustment of RGB pixels in fixed point
// with 2^FRACTION_BITS standing for one.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on red_in/green_in/blue_in with in_valid; a transfer happens
// at a clock edge with in_valid high and in_stall low. Results leave on
// red_out/green_out/blue_out with out_valid; the receiver holds out_stall
// high to keep a result in place.
// Gains are written through cfg_we/cfg_index/cfg_data while no pixel is in
// flight; indexes other than the three registers are ignored.
// One pixel is accepted per cycle while in_stall is low. The pipeline holds
// four renormalisers of FRACTION_BITS + 2 stages each, with their
// bit-per-stage dividers, plus six arithmetic stages.
// Reset clears every valid bit and loads all gains with one (65535 when one
// cannot be held in sixteen bits).
// When the receiver stalls, the pipeline keeps filling its empty stages and
// only raises in_stall once every stage from the input to the output is full.
// ----------------------------------------------------------------------------
module color_brightness_contrast_saturation
	import cbcs_pkg::*;
#(
	parameter int FRACTION_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [15:0]   red_in,
	input  logic signed [15:0]   green_in,
	input  logic signed [15:0]   blue_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [OUT_W-1:0]     red_out,
	output logic [OUT_W-1:0]     green_out,
	output logic [OUT_W-1:0]     blue_out,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data
);

	localparam int CW   = FRACTION_BITS + 1;
	localparam int ONE  = 1 << FRACTION_BITS;
	localparam int HALF = ONE / 2;
	localparam int LR   = (2125 * ONE + 5000) / 10000;
	localparam int LG   = (7154 * ONE + 5000) / 10000;
	localparam int LB   = (721 * ONE + 5000) / 10000;
	localparam bit UNIT_OK = (FRACTION_BITS < GAIN_W);
	localparam logic [GAIN_W-1:0] GAIN_RESET = UNIT_OK ? GAIN_W'(ONE) : '1;
	// contrast product, luma sum, grey level and saturation product widths
	localparam int PW1 = CW + 18;
	localparam int SW  = 2 * CW + 2;
	localparam int DW  = CW + 2;
	localparam int PW2 = DW + 18;
	localparam int TW  = PW2 + 1;

	localparam logic [CW-1:0] LR_C = CW'(LR);
	localparam logic [CW-1:0] LG_C = CW'(LG);
	localparam logic [CW-1:0] LB_C = CW'(LB);

	logic [GAIN_W-1:0] bri_q, sat_q, con_q;
	logic              bri_byp, sat_byp, con_byp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bri_q <= GAIN_RESET;
			sat_q <= GAIN_RESET;
			con_q <= GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_BRIGHTNESS: bri_q <= cfg_data;
				CFG_SATURATION: sat_q <= cfg_data;
				CFG_CONTRAST:   con_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign bri_byp = UNIT_OK && (bri_q == GAIN_RESET);
	assign sat_byp = UNIT_OK && (sat_q == GAIN_RESET);
	assign con_byp = UNIT_OK && (con_q == GAIN_RESET);

	// renormaliser connections
	logic signed [RENORM_W-1:0] rn0_in [3], rn1_in [3], rn2_in [3], rn3_in [3];
	logic [CW-1:0]              rn0_c [3], rn1_c [3], rn2_c [3], rn3_c [3];
	logic rn0_rdy, rn1_rdy, rn2_rdy, rn3_rdy;
	logic rn0_v, rn1_v, rn2_v;

	// stage valids and stall chain
	logic bri_v_s1, con_v_s1, con_v_s2, sat_v_s1, sat_v_s2, sat_v_s3;
	logic bri_rdy, con_rdy1, con_rdy2, sat_rdy1, sat_rdy2, sat_rdy3;

	assign sat_rdy3 = !sat_v_s3 || rn3_rdy;
	assign sat_rdy2 = !sat_v_s2 || sat_rdy3;
	assign sat_rdy1 = !sat_v_s1 || sat_rdy2;
	assign con_rdy2 = !con_v_s2 || rn2_rdy;
	assign con_rdy1 = !con_v_s1 || con_rdy2;
	assign bri_rdy  = !bri_v_s1 || rn1_rdy;
	assign in_stall = !rn0_rdy;

	// input renormalisation
	assign rn0_in[0] = RENORM_W'(red_in);
	assign rn0_in[1] = RENORM_W'(green_in);
	assign rn0_in[2] = RENORM_W'(blue_in);

	cbcs_renorm #(.FRACTION_BITS(FRACTION_BITS)) u_rn0 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(rn0_rdy), .in_c(rn0_in),
		.out_valid(rn0_v), .out_ready(bri_rdy), .out_c(rn0_c)
	);

	// brightness scaling
	logic signed [RENORM_W-1:0] bri_c_s1 [3];
	logic [CW+GAIN_W-1:0]       bri_p [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bri_p[i] = (CW+GAIN_W)'(rn0_c[i]) * (CW+GAIN_W)'(bri_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bri_v_s1 <= 1'b0;
		end else if (bri_rdy) begin
			bri_v_s1 <= rn0_v;
		end
	end

	always_ff @(posedge clk) begin
		if (bri_rdy) begin
			for (int i = 0; i < 3; i++) begin
				bri_c_s1[i] <= bri_byp ? signed'(RENORM_W'(rn0_c[i]))
					: signed'(RENORM_W'(bri_p[i] >> FRACTION_BITS));
			end
		end
	end

	assign rn1_in = bri_c_s1;

	cbcs_renorm #(.FRACTION_BITS(FRACTION_BITS)) u_rn1 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(bri_v_s1), .in_ready(rn1_rdy), .in_c(rn1_in),
		.out_valid(rn1_v), .out_ready(con_rdy1), .out_c(rn1_c)
	);

	// contrast: multiply offset from mid grey
	logic signed [PW1-1:0]      con_p_s1 [3];
	logic [CW-1:0]              con_c_s1 [3];
	logic signed [CW:0]         con_d [3];
	logic signed [PW1-1:0]      con_adj [3];
	logic signed [PW1-1:0]      con_r [3];
	logic signed [RENORM_W-1:0] con_c_s2 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			con_d[i] = signed'({1'b0, rn1_c[i]}) - signed'((CW+1)'(HALF));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			con_v_s1 <= 1'b0;
			con_v_s2 <= 1'b0;
		end else begin
			if (con_rdy1) con_v_s1 <= rn1_v;
			if (con_rdy2) con_v_s2 <= con_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (con_rdy1) begin
			for (int i = 0; i < 3; i++) begin
				con_p_s1[i] <= con_d[i] * signed'({1'b0, con_q});
				con_c_s1[i] <= rn1_c[i];
			end
		end
	end

	// contrast: divide toward zero and add mid grey back
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			con_adj[i] = con_p_s1[i][PW1-1]
				? con_p_s1[i] + signed'(PW1'(ONE - 1)) : con_p_s1[i];
			con_r[i] = (con_adj[i] >>> FRACTION_BITS) + signed'(PW1'(HALF));
		end
	end

	always_ff @(posedge clk) begin
		if (con_rdy2) begin
			for (int i = 0; i < 3; i++) begin
				con_c_s2[i] <= con_byp ? signed'(RENORM_W'(con_c_s1[i]))
					: signed'(con_r[i][RENORM_W-1:0]);
			end
		end
	end

	assign rn2_in = con_c_s2;

	cbcs_renorm #(.FRACTION_BITS(FRACTION_BITS)) u_rn2 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(con_v_s2), .in_ready(rn2_rdy), .in_c(rn2_in),
		.out_valid(rn2_v), .out_ready(sat_rdy1), .out_c(rn2_c)
	);

	// saturation: luminance weighted sum
	logic [SW-1:0]              sat_sum_s1;
	logic [CW-1:0]              sat_c_s1 [3];
	logic [DW-1:0]              sat_d;
	logic signed [DW:0]         sat_diff [3];
	logic signed [PW2-1:0]      sat_p_s2 [3];
	logic [DW-1:0]              sat_d_s2;
	logic [CW-1:0]              sat_c_s2 [3];
	logic signed [TW-1:0]       sat_t [3];
	logic signed [TW-1:0]       sat_adj [3];
	logic signed [TW-1:0]       sat_q3 [3];
	logic signed [RENORM_W-1:0] sat_c_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_v_s1 <= 1'b0;
			sat_v_s2 <= 1'b0;
			sat_v_s3 <= 1'b0;
		end else begin
			if (sat_rdy1) sat_v_s1 <= rn2_v;
			if (sat_rdy2) sat_v_s2 <= sat_v_s1;
			if (sat_rdy3) sat_v_s3 <= sat_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (sat_rdy1) begin
			sat_sum_s1 <= SW'(rn2_c[0]) * SW'(LR_C)
				+ SW'(rn2_c[1]) * SW'(LG_C) + SW'(rn2_c[2]) * SW'(LB_C);
			sat_c_s1 <= rn2_c;
		end
	end

	// saturation: grey level and weighted difference
	always_comb begin
		sat_d = sat_sum_s1[FRACTION_BITS+DW-1:FRACTION_BITS];
		for (int i = 0; i < 3; i++) begin
			sat_diff[i] = signed'((DW+1)'(sat_c_s1[i])) - signed'({1'b0, sat_d});
		end
	end

	always_ff @(posedge clk) begin
		if (sat_rdy2) begin
			for (int i = 0; i < 3; i++) begin
				sat_p_s2[i] <= sat_diff[i] * signed'({1'b0, sat_q});
			end
			sat_d_s2 <= sat_d;
			sat_c_s2 <= sat_c_s1;
		end
	end

	// saturation: add grey back and divide toward zero
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sat_t[i] = signed'(TW'(sat_d_s2) << FRACTION_BITS) + TW'(sat_p_s2[i]);
			sat_adj[i] = sat_t[i][TW-1] ? sat_t[i] + signed'(TW'(ONE - 1)) : sat_t[i];
			sat_q3[i] = sat_adj[i] >>> FRACTION_BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (sat_rdy3) begin
			for (int i = 0; i < 3; i++) begin
				sat_c_s3[i] <= sat_byp ? signed'(RENORM_W'(sat_c_s2[i]))
					: signed'(sat_q3[i][RENORM_W-1:0]);
			end
		end
	end

	assign rn3_in = sat_c_s3;

	cbcs_renorm #(.FRACTION_BITS(FRACTION_BITS)) u_rn3 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(sat_v_s3), .in_ready(rn3_rdy), .in_c(rn3_in),
		.out_valid(out_valid), .out_ready(!out_stall), .out_c(rn3_c)
	);

	// result fields
	assign red_out   = OUT_W'(rn3_c[0]);
	assign green_out = OUT_W'(rn3_c[1]);
	assign blue_out  = OUT_W'(rn3_c[2]);

endmodule
